### rtl/core/mte_pkg.sv
// Package for the multi-turn encoder tracker.
// Holds the sequencer state type, register indexes and fixed arithmetic constants.
// No dependencies.
package mte_pkg;

    // Sequencer states
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_READ,
        ST_STEP,
        ST_ANGLE,
        ST_SUM,
        ST_SUM_LAST,
        ST_DIV_MUL,
        ST_DIV_FIX,
        ST_DONE
    } state_t;

    // Configuration register indexes
    localparam int unsigned CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] CFG_YAW_BIAS   = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_PITCH_BIAS = 1'b1;

    // Register reset values
    localparam logic [12:0] YAW_BIAS_RST   = 13'd1160;
    localparam logic [12:0] PITCH_BIAS_RST = 13'd3000;

    // Unwrap and turn count limits
    localparam logic signed [13:0] WRAP_LIMIT = 14'sd7500;
    localparam logic signed [11:0] TURN_MAX   = 12'sd2047;
    localparam logic signed [14:0] TURN_STEP  = 15'sd8192;

    // Bias move window and gap
    localparam logic signed [25:0] BIAS_GAP    = 26'sd4000;
    localparam logic [7:0]         WINDOW_LOW  = 8'd90;
    localparam logic [7:0]         WINDOW_HIGH = 8'd100;
    localparam logic [7:0]         ITEM_MAX    = 8'd255;

    // Angle scaling: degrees * 256 / 8192 * 4 = 45 per count, 45 * 8192 per turn
    localparam logic signed [21:0] DEG_PER_COUNT = 22'sd45;
    localparam logic signed [30:0] DEG_PER_TURN  = 31'sd368640;

endpackage

### rtl/core/multi_turn_encoder_tracker_core.sv
// An accepted transaction passes through the read, step, angle, history sum, divide and done
// states before out_valid; the next one is taken only back in idle, after the serial walk over
// the rate history through the single read port of the history memory.
// A waiting result sits in the output register while the next transaction is taken.
// Reset (rst_n, async low) clears all control state and the valid bits of both
// memories, so entries never written read as zero; no clearing pass is needed.
// Depends on mte_pkg.
module multi_turn_encoder_tracker_core #(
    parameter int RATE_DEPTH = 8
) (
    input  logic                             clk,
    input  logic                             rst_n,
    // configuration write port
    input  logic                             cfg_we,
    input  logic [mte_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [12:0]                      cfg_wdata,
    // input channel
    input  logic                             in_valid,
    output logic                             in_stall,
    input  logic                             channel,
    input  logic [12:0]                      raw_position,
    // output channel
    output logic                             out_valid,
    input  logic                             out_stall,
    output logic                             out_channel,
    output logic signed [24:0]               turn_position,
    output logic signed [28:0]               angle_degrees_q8,
    output logic signed [13:0]               step_rate,
    output logic signed [13:0]               mean_rate,
    output logic signed [11:0]               turns,
    output logic signed [14:0]               current_bias
);

    localparam int SLOT_W   = (RATE_DEPTH > 1) ? $clog2(RATE_DEPTH) : 1;
    localparam int ADDR_W   = $clog2(2 * RATE_DEPTH);
    localparam int HIST_N   = 2 * RATE_DEPTH;
    localparam int SUM_W    = 14 + $clog2(RATE_DEPTH);
    localparam int RECIP_W  = SUM_W + 1;
    localparam int DPROD_W  = SUM_W + RECIP_W;
    localparam int CHAN_W   = 13 + 12 + SLOT_W;
    localparam logic [RECIP_W-1:0] RECIP = RECIP_W'((1 << SUM_W) / RATE_DEPTH);
    localparam logic [SLOT_W-1:0]  SLOT_LAST = SLOT_W'(RATE_DEPTH - 1);

    // ------------------------------------------------------------------
    // Control state
    // ------------------------------------------------------------------
    mte_pkg::state_t state_reg, state_next;

    logic [7:0]               item_cnt_reg;
    logic [12:0]              yaw_offset_reg;
    logic [12:0]              pitch_offset_reg;
    logic signed [14:0]       bias_reg [2];
    logic [1:0]               chan_vld_reg;
    logic [HIST_N-1:0]        hist_vld_reg;
    logic [SLOT_W-1:0]        rd_cnt_reg;
    logic                     rd_pend_reg;
    logic                     out_valid_reg;

    // Sequencer outputs
    logic accept;
    logic step_en;
    logic angle_en;
    logic sum_issue;
    logic div_mul_en;
    logic div_fix_en;
    logic out_load;

    // ------------------------------------------------------------------
    // Memories and their registered read data
    // ------------------------------------------------------------------
    logic [CHAN_W-1:0]        chan_mem [0:1];
    logic [CHAN_W-1:0]        chan_rd_reg;
    logic                     chan_rd_vld_reg;
    logic [13:0]              hist_mem [0:HIST_N-1];
    logic [13:0]              hist_rd_reg;
    logic                     hist_rd_vld_reg;

    // ------------------------------------------------------------------
    // Datapath registers
    // ------------------------------------------------------------------
    logic                     ch_reg;
    logic [12:0]              raw_reg;
    logic signed [21:0]       prod_a_reg;
    logic signed [30:0]       prod_b_reg;
    logic signed [28:0]       angle_reg;
    logic signed [24:0]       res_pos_reg;
    logic signed [13:0]       res_rate_reg;
    logic signed [11:0]       res_turns_reg;
    logic signed [14:0]       res_bias_reg;
    logic signed [SUM_W-1:0]  acc_reg;
    logic [SUM_W-1:0]         abs_reg;
    logic                     neg_reg;
    logic [DPROD_W-1:0]       dprod_reg;
    logic [12:0]              q0_reg;
    logic [SUM_W-1:0]         qd_reg;

    // Output registers
    logic                     o_ch_reg;
    logic signed [24:0]       o_pos_reg;
    logic signed [28:0]       o_angle_reg;
    logic signed [13:0]       o_rate_reg;
    logic signed [13:0]       o_mean_reg;
    logic signed [11:0]       o_turns_reg;
    logic signed [14:0]       o_bias_reg;

    // ------------------------------------------------------------------
    // Sequencer: next state
    // ------------------------------------------------------------------
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            mte_pkg::ST_IDLE:     if (in_valid) state_next = mte_pkg::ST_READ;
            mte_pkg::ST_READ:     state_next = mte_pkg::ST_STEP;
            mte_pkg::ST_STEP:     state_next = mte_pkg::ST_ANGLE;
            mte_pkg::ST_ANGLE:    state_next = mte_pkg::ST_SUM;
            mte_pkg::ST_SUM:      if (rd_cnt_reg == SLOT_LAST) state_next = mte_pkg::ST_SUM_LAST;
            mte_pkg::ST_SUM_LAST: state_next = mte_pkg::ST_DIV_MUL;
            mte_pkg::ST_DIV_MUL:  state_next = mte_pkg::ST_DIV_FIX;
            mte_pkg::ST_DIV_FIX:  state_next = mte_pkg::ST_DONE;
            mte_pkg::ST_DONE:     if (!out_valid_reg || !out_stall) state_next = mte_pkg::ST_IDLE;
            default:              state_next = mte_pkg::ST_IDLE;
        endcase
    end

    // ------------------------------------------------------------------
    // Sequencer: outputs
    // ------------------------------------------------------------------
    always_comb
    begin
        in_stall   = 1'b1;
        accept     = 1'b0;
        step_en    = 1'b0;
        angle_en   = 1'b0;
        sum_issue  = 1'b0;
        div_mul_en = 1'b0;
        div_fix_en = 1'b0;
        out_load   = 1'b0;
        case (state_reg)
            mte_pkg::ST_IDLE:
            begin
                in_stall = 1'b0;
                accept   = in_valid;
            end
            mte_pkg::ST_STEP:    step_en    = 1'b1;
            mte_pkg::ST_ANGLE:   angle_en   = 1'b1;
            mte_pkg::ST_SUM:     sum_issue  = 1'b1;
            mte_pkg::ST_DIV_MUL: div_mul_en = 1'b1;
            mte_pkg::ST_DIV_FIX: div_fix_en = 1'b1;
            mte_pkg::ST_DONE:    out_load   = !out_valid_reg || !out_stall;
            default:             in_stall   = 1'b1;
        endcase
    end

    // ------------------------------------------------------------------
    // Step logic: unwrap, turn count, products, bias move
    // ------------------------------------------------------------------
    logic [12:0]              prev_pos;
    logic signed [11:0]       turn_old;
    logic [SLOT_W-1:0]        slot_cur;
    logic [SLOT_W-1:0]        slot_nxt;
    logic signed [13:0]       diff;
    logic signed [14:0]       rate_wide;
    logic signed [13:0]       rate;
    logic signed [11:0]       turn_new;
    logic signed [24:0]       pos;
    logic signed [14:0]       bias_old;
    logic signed [15:0]       raw_minus_bias;
    logic signed [21:0]       prod_a_next;
    logic signed [30:0]       prod_b_next;
    logic signed [25:0]       bias_gap;
    logic [12:0]              offset;
    logic                     in_window;
    logic signed [14:0]       bias_new;
    logic [ADDR_W-1:0]        hist_waddr;
    logic [ADDR_W-1:0]        hist_raddr;
    logic [ADDR_W-1:0]        hist_base;

    always_comb
    begin
        prev_pos = chan_rd_vld_reg ? chan_rd_reg[CHAN_W-1 -: 13] : 13'd0;
        turn_old = chan_rd_vld_reg ? $signed(chan_rd_reg[SLOT_W +: 12]) : 12'sd0;
        slot_cur = chan_rd_vld_reg ? chan_rd_reg[SLOT_W-1:0] : '0;
        slot_nxt = (slot_cur == SLOT_LAST) ? '0 : slot_cur + SLOT_W'(1);

        diff      = $signed({1'b0, raw_reg}) - $signed({1'b0, prev_pos});
        turn_new  = turn_old;
        rate_wide = {diff[13], diff};
        if (diff < -mte_pkg::WRAP_LIMIT)
        begin
            if (turn_old != mte_pkg::TURN_MAX)
                turn_new = turn_old + 12'sd1;
            rate_wide = {diff[13], diff} + mte_pkg::TURN_STEP;
        end
        else if (diff > mte_pkg::WRAP_LIMIT)
        begin
            if (turn_old != -mte_pkg::TURN_MAX)
                turn_new = turn_old - 12'sd1;
            rate_wide = {diff[13], diff} - mte_pkg::TURN_STEP;
        end
        rate = rate_wide[13:0];
        pos  = $signed({turn_new, raw_reg});

        // angle products, added in the next cycle
        bias_old       = bias_reg[ch_reg];
        raw_minus_bias = $signed({3'b000, raw_reg}) - {bias_old[14], bias_old};
        prod_a_next    = 22'(raw_minus_bias) * mte_pkg::DEG_PER_COUNT;
        prod_b_next    = 31'(turn_new) * mte_pkg::DEG_PER_TURN;

        // bias move by a full turn inside the item window
        bias_gap  = 26'(bias_old) - 26'(pos);
        offset    = ch_reg ? pitch_offset_reg : yaw_offset_reg;
        in_window = (item_cnt_reg >= mte_pkg::WINDOW_LOW) &&
                    (item_cnt_reg <= mte_pkg::WINDOW_HIGH);
        bias_new  = bias_old;
        if (in_window)
        begin
            if (bias_gap < -mte_pkg::BIAS_GAP)
                bias_new = $signed({2'b00, offset}) + mte_pkg::TURN_STEP;
            else if (bias_gap > mte_pkg::BIAS_GAP)
                bias_new = $signed({2'b00, offset}) - mte_pkg::TURN_STEP;
        end

        // history addresses: channel rows of RATE_DEPTH entries
        hist_base  = ch_reg ? ADDR_W'(RATE_DEPTH) : '0;
        hist_waddr = hist_base + ADDR_W'(slot_cur);
        hist_raddr = hist_base + ADDR_W'(rd_cnt_reg);
    end

    // ------------------------------------------------------------------
    // Angle: sum of products, divided by 4 toward zero
    // ------------------------------------------------------------------
    logic signed [31:0] angle_num;
    logic signed [31:0] angle_adj;

    always_comb
    begin
        angle_num = 32'(prod_a_reg) + 32'(prod_b_reg);
        angle_adj = angle_num + (angle_num[31] ? 32'sd3 : 32'sd0);
    end

    // ------------------------------------------------------------------
    // Mean: reciprocal multiply with one correction step
    // ------------------------------------------------------------------
    logic [SUM_W-1:0]   abs_next;
    logic [12:0]        q0_next;
    logic [SUM_W-1:0]   rem;
    logic [13:0]        quot;
    logic signed [13:0] mean_val;

    always_comb
    begin
        abs_next = acc_reg[SUM_W-1] ? $unsigned(-acc_reg) : $unsigned(acc_reg);
        q0_next  = dprod_reg[SUM_W +: 13];
        rem      = abs_reg - qd_reg;
        quot     = {1'b0, q0_reg} + ((rem >= SUM_W'(RATE_DEPTH)) ? 14'd1 : 14'd0);
        mean_val = neg_reg ? -$signed(quot) : $signed(quot);
    end

    // ------------------------------------------------------------------
    // Control registers
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= mte_pkg::ST_IDLE;
            item_cnt_reg     <= 8'd0;
            yaw_offset_reg   <= mte_pkg::YAW_BIAS_RST;
            pitch_offset_reg <= mte_pkg::PITCH_BIAS_RST;
            bias_reg[0]      <= 15'sd0;
            bias_reg[1]      <= 15'sd0;
            chan_vld_reg     <= 2'b00;
            hist_vld_reg     <= '0;
            rd_cnt_reg       <= '0;
            rd_pend_reg      <= 1'b0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;

            // configuration writes
            if (cfg_we)
            begin
                case (cfg_index)
                    mte_pkg::CFG_YAW_BIAS:   yaw_offset_reg   <= cfg_wdata;
                    mte_pkg::CFG_PITCH_BIAS: pitch_offset_reg <= cfg_wdata;
                    default:                 yaw_offset_reg   <= yaw_offset_reg;
                endcase
            end

            // item counter, bias load on the first transaction
            if (accept)
            begin
                if (item_cnt_reg != mte_pkg::ITEM_MAX)
                    item_cnt_reg <= item_cnt_reg + 8'd1;
                if (item_cnt_reg == 8'd0)
                begin
                    bias_reg[0] <= $signed({2'b00, yaw_offset_reg});
                    bias_reg[1] <= $signed({2'b00, pitch_offset_reg});
                end
            end

            // step write-back
            if (step_en)
            begin
                bias_reg[ch_reg]         <= bias_new;
                chan_vld_reg[ch_reg]     <= 1'b1;
                hist_vld_reg[hist_waddr] <= 1'b1;
            end

            // history walk
            if (angle_en)
                rd_cnt_reg <= '0;
            else if (sum_issue)
                rd_cnt_reg <= rd_cnt_reg + SLOT_W'(1);
            rd_pend_reg <= sum_issue;

            // output register
            if (out_load)
                out_valid_reg <= 1'b1;
            else if (!out_stall)
                out_valid_reg <= 1'b0;
        end
    end

    // ------------------------------------------------------------------
    // Channel state memory: previous position, turn count, history slot
    // ------------------------------------------------------------------
    always_ff @(posedge clk)
    begin
        if (step_en)
            chan_mem[ch_reg] <= {raw_reg, turn_new, slot_nxt};
        if (accept)
        begin
            chan_rd_reg     <= chan_mem[channel];
            chan_rd_vld_reg <= chan_vld_reg[channel];
        end
    end

    // ------------------------------------------------------------------
    // Rate history memory: one write in the step, serial reads after it
    // ------------------------------------------------------------------
    always_ff @(posedge clk)
    begin
        if (step_en)
            hist_mem[hist_waddr] <= rate;
        if (sum_issue)
        begin
            hist_rd_reg     <= hist_mem[hist_raddr];
            hist_rd_vld_reg <= hist_vld_reg[hist_raddr];
        end
    end

    // ------------------------------------------------------------------
    // Datapath registers
    // ------------------------------------------------------------------
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            ch_reg  <= channel;
            raw_reg <= raw_position;
        end

        if (step_en)
        begin
            prod_a_reg    <= prod_a_next;
            prod_b_reg    <= prod_b_next;
            res_pos_reg   <= pos;
            res_rate_reg  <= rate;
            res_turns_reg <= turn_new;
            res_bias_reg  <= bias_new;
        end

        if (angle_en)
        begin
            angle_reg <= 29'(angle_adj >>> 2);
            acc_reg   <= '0;
        end
        else if (rd_pend_reg)
        begin
            acc_reg <= acc_reg + (hist_rd_vld_reg ? SUM_W'($signed(hist_rd_reg)) : '0);
        end

        if (div_mul_en)
        begin
            abs_reg   <= abs_next;
            neg_reg   <= acc_reg[SUM_W-1];
            dprod_reg <= DPROD_W'(abs_next) * DPROD_W'(RECIP);
        end

        if (div_fix_en)
        begin
            q0_reg <= q0_next;
            qd_reg <= SUM_W'(q0_next * RATE_DEPTH);
        end

        if (out_load)
        begin
            o_ch_reg    <= ch_reg;
            o_pos_reg   <= res_pos_reg;
            o_angle_reg <= angle_reg;
            o_rate_reg  <= res_rate_reg;
            o_mean_reg  <= mean_val;
            o_turns_reg <= res_turns_reg;
            o_bias_reg  <= res_bias_reg;
        end
    end

    // Output ports
    assign out_valid        = out_valid_reg;
    assign out_channel      = o_ch_reg;
    assign turn_position    = o_pos_reg;
    assign angle_degrees_q8 = o_angle_reg;
    assign step_rate        = o_rate_reg;
    assign mean_rate        = o_mean_reg;
    assign turns            = o_turns_reg;
    assign current_bias     = o_bias_reg;

`ifndef SYNTHESIS
    // A new result only comes from the final sequencer state
    a_result_from_done: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == mte_pkg::ST_DONE))
        else $error("result loaded outside the final state");

    // An accepted transaction always starts with the channel state read
    a_accept_reads: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> (state_reg == mte_pkg::ST_READ))
        else $error("accepted transaction did not start a channel read");

    // Turn count stays inside its saturation range
    a_turns_sat: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (o_turns_reg != -12'sd2048))
        else $error("turn count left its saturation range");

    // Mean never reaches the one code outside the rate range
    a_mean_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (o_mean_reg != -14'sd8192))
        else $error("mean rate out of range");

    // History reads are only pending right after an issued read
    a_read_pend: assert property (@(posedge clk) disable iff (!rst_n)
        rd_pend_reg |-> ((state_reg == mte_pkg::ST_SUM) ||
                         (state_reg == mte_pkg::ST_SUM_LAST)))
        else $error("history read data arrived outside the walk");
`endif

endmodule
